### rtl/core/ghf_pkg.sv
// shared types, constants and helpers for the hole-filling height grid
package ghf_pkg;

    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int HGT_W     = 16;
    localparam int DIM_W     = 7;
    localparam int CELL_W    = HGT_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [DIM_W-1:0] RESET_DIM = 7'd64;

    typedef enum logic [1:0] {
        ST_PRESENT,
        ST_FILLED,
        ST_NONE
    } t_status;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_REJECT
    } t_op;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_OWN,
        B_CHK,
        B_SCAN,
        B_MIN
    } t_back_state;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_area;

    typedef struct packed {
        t_op                     op;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [HGT_W-1:0] height;
        logic                    missing;
    } t_entry;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > lim) begin
            res = lim;
        end
        return res;
    endfunction

endpackage

### rtl/core/ghf_in_if.sv
// input channel carrying write and query items
interface ghf_in_if;
    import ghf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [HGT_W-1:0] height;
    logic                    missing;

    modport source (output valid, mode, row, col, height, missing, input ready);
    modport sink   (input valid, mode, row, col, height, missing, output ready);
endinterface

### rtl/core/ghf_out_if.sv
// result channel carrying filled heights and status
interface ghf_out_if;
    import ghf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [HGT_W-1:0] fill_value;
    logic [1:0]              status;

    modport source (output valid, fill_value, status, input ready);
    modport sink   (input valid, fill_value, status, output ready);
endinterface

### rtl/core/ghf_front.sv
// front end: accepts items, classifies them and queues them for the back end
module ghf_front #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ghf_in_if.sink          i_in,
    input  ghf_pkg::t_area  i_area,
    input  logic            i_clr_done,
    input  logic            i_pop,
    output logic            o_q_valid,
    output ghf_pkg::t_entry o_q_entry
);
    import ghf_pkg::*;

    localparam int QAW = $clog2(Q_DEPTH);
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_entry         r_q [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;

    t_entry in_entry;
    logic   accept;
    logic   drop;
    logic   push;

    assign i_in.ready = i_clr_done && (r_cnt != QCW'(Q_DEPTH));
    assign accept     = i_in.valid && i_in.ready;
    assign push       = accept && !drop;

    always_comb begin
        in_entry.row     = i_in.row;
        in_entry.col     = i_in.col;
        in_entry.height  = i_in.height;
        in_entry.missing = i_in.missing;
        in_entry.op      = OP_QUERY;
        drop             = 1'b0;
        if (i_in.mode == MODE_WRITE) begin
            in_entry.op = OP_WRITE;
            // writes beyond the store are dropped here
            drop = (int'(i_in.row) >= MAX_ROWS) || (int'(i_in.col) >= MAX_COLS);
        end else if ((DIM_W'(i_in.row) >= i_area.rows) ||
                     (DIM_W'(i_in.col) >= i_area.cols)) begin
            in_entry.op = OP_REJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QAW'(Q_DEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(Q_DEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_entry;
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_entry = r_q[r_rp];

endmodule

### rtl/core/ghf_back.sv
// back end: grid store copies, nearest-present scan in four directions, result register
module ghf_back #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ghf_pkg::t_area  i_area,
    input  logic            i_q_valid,
    input  ghf_pkg::t_entry i_q_entry,
    output logic            o_pop,
    output logic            o_clr_done,
    ghf_out_if.source       o_res
);
    import ghf_pkg::*;

    // rows or columns beyond what the index fields reach are never written
    localparam int MR    = (MAX_ROWS < (2 ** ROW_W)) ? MAX_ROWS : (2 ** ROW_W);
    localparam int MC    = (MAX_COLS < (2 ** COL_W)) ? MAX_COLS : (2 ** COL_W);
    localparam int RW    = $clog2(MR);
    localparam int CW    = $clog2(MC);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    localparam int N_DIR   = 4;
    localparam int D_UP    = 0;
    localparam int D_LEFT  = 1;
    localparam int D_DOWN  = 2;
    localparam int D_RIGHT = 3;

    t_back_state r_state;
    t_back_state n_state;

    // two copies so that four cells can be read each cycle
    logic [CELL_W-1:0] r_mem_v [DEPTH];
    logic [CELL_W-1:0] r_mem_h [DEPTH];
    logic [CELL_W-1:0] r_rd    [N_DIR];

    logic [AW-1:0]           r_clr_addr;
    logic [RW-1:0]           r_qr;
    logic [CW-1:0]           r_qc;
    logic [RW-1:0]           r_ptr_u;
    logic [RW-1:0]           r_ptr_d;
    logic [CW-1:0]           r_ptr_l;
    logic [CW-1:0]           r_ptr_r;
    logic [N_DIR-1:0]        r_act;
    logic [N_DIR-1:0]        r_pend;
    logic [N_DIR-1:0]        r_fnd;
    logic signed [HGT_W-1:0] r_fval [N_DIR];

    logic                    r_out_valid;
    logic signed [HGT_W-1:0] r_out_val;
    t_status                 r_out_st;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [CELL_W-1:0]       mem_wdata;
    logic [AW-1:0]           va_addr;
    logic [AW-1:0]           vb_addr;
    logic [AW-1:0]           ha_addr;
    logic [AW-1:0]           hb_addr;
    logic                    out_free;
    logic                    out_load;
    logic signed [HGT_W-1:0] out_val_n;
    t_status                 out_st_n;
    logic                    q_latch;
    logic                    dir_init;
    logic [N_DIR-1:0]        hit;
    logic [N_DIR-1:0]        last;
    logic signed [HGT_W-1:0] best_val;
    logic                    best_fnd;

    assign out_free   = !r_out_valid || o_res.ready;
    assign o_clr_done = (r_state != B_CLEAR);

    assign va_addr = (r_state == B_OWN) ? {r_qr, r_qc} : {r_ptr_u, r_qc};
    assign vb_addr = {r_ptr_d, r_qc};
    assign ha_addr = {r_qr, r_ptr_l};
    assign hb_addr = {r_qr, r_ptr_r};

    always_comb begin
        for (int d = 0; d < N_DIR; d++) begin
            hit[d] = r_pend[d] && !r_rd[d][HGT_W];
        end
        last[D_UP]    = (r_ptr_u == '0);
        last[D_LEFT]  = (r_ptr_l == '0);
        last[D_DOWN]  = ((DIM_W'(r_ptr_d) + DIM_W'(1)) == i_area.rows);
        last[D_RIGHT] = ((DIM_W'(r_ptr_r) + DIM_W'(1)) == i_area.cols);
    end

    // least of the heights found, signed
    always_comb begin
        best_val = '0;
        best_fnd = 1'b0;
        for (int d = 0; d < N_DIR; d++) begin
            if (r_fnd[d] && (!best_fnd || (r_fval[d] < best_val))) begin
                best_val = r_fval[d];
                best_fnd = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = {RW'(i_q_entry.row), CW'(i_q_entry.col)};
        mem_wdata = {i_q_entry.missing, i_q_entry.height};
        o_pop     = 1'b0;
        out_load  = 1'b0;
        out_val_n = '0;
        out_st_n  = ST_NONE;
        q_latch   = 1'b0;
        dir_init  = 1'b0;
        case (r_state)
            B_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = {1'b1, HGT_W'(0)};
                if (r_clr_addr == '1) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_entry.op)
                        OP_WRITE: begin
                            o_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_REJECT: begin
                            if (out_free) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            if (out_free) begin
                                o_pop   = 1'b1;
                                q_latch = 1'b1;
                                n_state = B_OWN;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_OWN: begin
                n_state = B_CHK;
            end
            B_CHK: begin
                if (!r_rd[D_UP][HGT_W]) begin
                    out_load  = 1'b1;
                    out_val_n = r_rd[D_UP][HGT_W-1:0];
                    out_st_n  = ST_PRESENT;
                    n_state   = B_IDLE;
                end else begin
                    dir_init = 1'b1;
                    n_state  = B_SCAN;
                end
            end
            B_SCAN: begin
                if ((r_act == '0) && (r_pend == '0)) begin
                    n_state = B_MIN;
                end
            end
            B_MIN: begin
                out_load = 1'b1;
                if (best_fnd) begin
                    out_val_n = best_val;
                    out_st_n  = ST_FILLED;
                end
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_v[mem_waddr] <= mem_wdata;
            r_mem_h[mem_waddr] <= mem_wdata;
        end
        r_rd[D_UP]    <= r_mem_v[va_addr];
        r_rd[D_DOWN]  <= r_mem_v[vb_addr];
        r_rd[D_LEFT]  <= r_mem_h[ha_addr];
        r_rd[D_RIGHT] <= r_mem_h[hb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_act       <= '0;
            r_pend      <= '0;
            r_fnd       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (dir_init) begin
                r_act[D_UP]    <= (r_qr != '0);
                r_act[D_LEFT]  <= (r_qc != '0);
                r_act[D_DOWN]  <= ((DIM_W'(r_qr) + DIM_W'(1)) < i_area.rows);
                r_act[D_RIGHT] <= ((DIM_W'(r_qc) + DIM_W'(1)) < i_area.cols);
                r_pend         <= '0;
                r_fnd          <= '0;
            end else if (r_state == B_SCAN) begin
                for (int d = 0; d < N_DIR; d++) begin
                    if (hit[d]) begin
                        // nearest present cell seen, the read in flight is discarded
                        r_fnd[d]  <= 1'b1;
                        r_act[d]  <= 1'b0;
                        r_pend[d] <= 1'b0;
                    end else begin
                        r_pend[d] <= r_act[d];
                        if (r_act[d] && last[d]) begin
                            r_act[d] <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_latch) begin
            r_qr <= RW'(i_q_entry.row);
            r_qc <= CW'(i_q_entry.col);
        end
        if (dir_init) begin
            r_ptr_u <= r_qr - RW'(1);
            r_ptr_d <= r_qr + RW'(1);
            r_ptr_l <= r_qc - CW'(1);
            r_ptr_r <= r_qc + CW'(1);
        end else if (r_state == B_SCAN) begin
            if (r_act[D_UP]) begin
                r_ptr_u <= r_ptr_u - RW'(1);
            end
            if (r_act[D_DOWN]) begin
                r_ptr_d <= r_ptr_d + RW'(1);
            end
            if (r_act[D_LEFT]) begin
                r_ptr_l <= r_ptr_l - CW'(1);
            end
            if (r_act[D_RIGHT]) begin
                r_ptr_r <= r_ptr_r + CW'(1);
            end
            for (int d = 0; d < N_DIR; d++) begin
                if (hit[d]) begin
                    r_fval[d] <= r_rd[d][HGT_W-1:0];
                end
            end
        end
        if (out_load) begin
            r_out_val <= out_val_n;
            r_out_st  <= out_st_n;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.fill_value = r_out_val;
    assign o_res.status     = r_out_st;

endmodule

### rtl/core/grid_hole_fill_nearest_min.sv
// top level of the hole-filling height grid with nearest-present minimum
// order: a write is queued, then stored; a query outside the area in use is answered without a scan,
// one on a present cell after its own-cell read, a filled one after the four-way scan and the minimum
// throughput: one query at a time, set by the four-way scan over the two dual-read grid copies
// reset: synchronous; a clearing pass over every address of the store
// marks every cell missing, and no item is accepted until it ends
module grid_hole_fill_nearest_min #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ghf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ghf_pkg::DIM_W-1:0]       i_cfg_data,
    ghf_in_if.sink                          i_in,
    ghf_out_if.source                       o_res
);
    import ghf_pkg::*;

    localparam int MR = (MAX_ROWS < (2 ** ROW_W)) ? MAX_ROWS : (2 ** ROW_W);
    localparam int MC = (MAX_COLS < (2 ** COL_W)) ? MAX_COLS : (2 ** COL_W);

    t_area  r_area;
    logic   q_valid;
    t_entry q_entry;
    logic   q_pop;
    logic   clr_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area.rows <= clamp_dim(RESET_DIM, DIM_W'(MR));
            r_area.cols <= clamp_dim(RESET_DIM, DIM_W'(MC));
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_area.rows <= clamp_dim(i_cfg_data, DIM_W'(MR));
                CFG_COLS: r_area.cols <= clamp_dim(i_cfg_data, DIM_W'(MC));
                default: ;
            endcase
        end
    end

    ghf_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_area     (r_area),
        .i_clr_done (clr_done),
        .i_pop      (q_pop),
        .o_q_valid  (q_valid),
        .o_q_entry  (q_entry)
    );

    ghf_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_area     (r_area),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_pop      (q_pop),
        .o_clr_done (clr_done),
        .o_res      (o_res)
    );

endmodule

### rtl/core/ghf_chk.sv
// port-level checks for the hole-filling height grid, bound to the top level
module ghf_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                i_out_status,
    input logic [ghf_pkg::HGT_W-1:0] i_out_value
);
    import ghf_pkg::*;

    // a no-neighbour result always carries a zero height
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status == ST_NONE)) |-> (i_out_value == '0))
        else $error("no-neighbour result with non-zero height");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_status) && $stable(i_out_value)))
        else $error("stalled result changed");

    // the clearing pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input open during clearing pass");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

endmodule

bind grid_hole_fill_nearest_min ghf_chk u_ghf_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_status (o_res.status),
    .i_out_value  (o_res.fill_value)
);
